// ----- hw/rtl/nec_ir_pkg.sv -----
`default_nettype none
package nec_ir_pkg;

  localparam int DUR_W    = 16;
  localparam int DATA_W   = 32;
  localparam int TOL_W    = 7;
  localparam int CFG_IDX_W = 8;
  localparam int IDX_W    = 6;

  localparam int unsigned T_HDR_MARK   = 9000;
  localparam int unsigned T_HDR_SPACE  = 4500;
  localparam int unsigned T_SHORT      = 560;
  localparam int unsigned T_ONE_SPACE  = 1690;
  localparam int unsigned T_REP_SPACE  = 2250;

  localparam logic [TOL_W-1:0] HDR_TOL_RST = 7'd25;
  localparam logic [TOL_W-1:0] BIT_TOL_RST = 7'd30;

  localparam logic [CFG_IDX_W-1:0] CFG_HDR_TOL = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BIT_TOL = 8'd1;

  localparam logic [2:0] PH_HDR_MARK  = 3'd0;
  localparam logic [2:0] PH_HDR_SPACE = 3'd1;
  localparam logic [2:0] PH_REP_MARK  = 3'd2;
  localparam logic [2:0] PH_BIT_MARK  = 3'd3;
  localparam logic [2:0] PH_BIT_SPACE = 3'd4;
  localparam logic [2:0] PH_TAIL      = 3'd5;
  localparam logic [2:0] PH_DONE      = 3'd6;

  localparam logic [1:0] V_UNDECIDED = 2'd0;
  localparam logic [1:0] V_REPEAT    = 2'd1;
  localparam logic [1:0] V_REJECT    = 2'd2;
  localparam logic [1:0] V_DATA      = 2'd3;

  localparam logic [1:0] ST_FRAME  = 2'd0;
  localparam logic [1:0] ST_REPEAT = 2'd1;
  localparam logic [1:0] ST_REJECT = 2'd2;

  localparam logic [1:0] AHC_MAX = 2'd3;
  localparam logic [1:0] AHC_SHORT_MAX = 2'd2;
  localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DATA_W - 1);
  localparam logic [7:0] BYTE_ONES = 8'hFF;

  typedef struct packed {
    logic             is_mark;
    logic [DUR_W-1:0] duration_us;
    logic             last;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] address;
    logic [7:0]  command;
    logic        short_address;
  } out_item_t;

  typedef struct packed {
    logic [TOL_W-1:0] hdr_tol;
    logic [TOL_W-1:0] bit_tol;
  } tol_cfg_t;

endpackage
`default_nettype wire

// ----- hw/rtl/nec_ir_window.sv -----
`default_nettype none
module nec_ir_window
  import nec_ir_pkg::*;
#(
  parameter int unsigned TARGET = 560
) (
  input  wire logic [DUR_W-1:0] dur,
  input  wire logic [TOL_W-1:0] tol,
  output logic                  hit
);

  // |d - t| <= floor(t * p / 100)  <=>  100 * |d - t| <= t * p
  localparam int CMP_W = DUR_W + 7;
  localparam logic [DUR_W-1:0] TGT = DUR_W'(TARGET);

  logic [DUR_W-1:0] diff;
  logic [CMP_W-1:0] diff_x100;
  logic [CMP_W-1:0] limit;

  always_comb begin
    diff      = (dur >= TGT) ? (dur - TGT) : (TGT - dur);
    diff_x100 = CMP_W'(diff) * CMP_W'(100);
    limit     = CMP_W'(TARGET) * CMP_W'(tol);
    hit       = (diff_x100 <= limit);
  end

endmodule
`default_nettype wire

// ----- hw/rtl/nec_ir_fsm.sv -----
`default_nettype none
module nec_ir_fsm
  import nec_ir_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      step,
  input  wire in_item_t  pulse,
  input  wire tol_cfg_t  tol,
  output out_item_t      result
);

  logic [2:0]        ph_r, ph_nxt;
  logic [IDX_W-1:0]  idx_r, idx_nxt;
  logic [DATA_W-1:0] sh_r, sh_nxt;
  logic [1:0]        ahc_r, ahc_nxt;
  logic              fao_r, fao_nxt;
  logic [1:0]        vd_r, vd_nxt;

  logic hit_hm, hit_hs, hit_rs, hit_short, hit_one;
  logic mk;
  logic in_bits;
  logic [7:0] lo, hi, cmd, inv;

  assign mk = pulse.is_mark;

  nec_ir_window #(.TARGET(T_HDR_MARK)) u_win_hm (
    .dur(pulse.duration_us), .tol(tol.hdr_tol), .hit(hit_hm));
  nec_ir_window #(.TARGET(T_HDR_SPACE)) u_win_hs (
    .dur(pulse.duration_us), .tol(tol.hdr_tol), .hit(hit_hs));
  nec_ir_window #(.TARGET(T_REP_SPACE)) u_win_rs (
    .dur(pulse.duration_us), .tol(tol.bit_tol), .hit(hit_rs));
  nec_ir_window #(.TARGET(T_SHORT)) u_win_short (
    .dur(pulse.duration_us), .tol(tol.bit_tol), .hit(hit_short));
  nec_ir_window #(.TARGET(T_ONE_SPACE)) u_win_one (
    .dur(pulse.duration_us), .tol(tol.bit_tol), .hit(hit_one));

  always_comb begin
    ph_nxt  = ph_r;
    idx_nxt = idx_r;
    sh_nxt  = sh_r;
    ahc_nxt = ahc_r;
    fao_nxt = fao_r;
    vd_nxt  = vd_r;
    unique case (ph_r) inside
      PH_HDR_MARK: begin
        if (mk && hit_hm) begin
          ph_nxt = PH_HDR_SPACE;
        end else begin
          vd_nxt = V_REJECT;
          ph_nxt = PH_DONE;
        end
      end
      PH_HDR_SPACE: begin
        // repeat space wins when both windows match
        if (!mk && hit_rs) begin
          ph_nxt = PH_REP_MARK;
        end else if (!mk && hit_hs) begin
          ph_nxt  = PH_BIT_MARK;
          idx_nxt = '0;
          sh_nxt  = '0;
          ahc_nxt = '0;
          fao_nxt = 1'b0;
        end else begin
          vd_nxt = V_REJECT;
          ph_nxt = PH_DONE;
        end
      end
      PH_REP_MARK: begin
        vd_nxt = (mk && hit_short) ? V_REPEAT : V_REJECT;
        ph_nxt = PH_DONE;
      end
      PH_BIT_MARK, PH_BIT_SPACE, PH_TAIL: begin
        if (ahc_r == '0) begin
          fao_nxt = mk && hit_short;
        end
        if (ahc_r != AHC_MAX) begin
          ahc_nxt = ahc_r + 2'd1;
        end
        if (ph_r == PH_BIT_MARK) begin
          if (mk && hit_short) begin
            ph_nxt = PH_BIT_SPACE;
          end else begin
            vd_nxt = V_REJECT;
            ph_nxt = PH_TAIL;
          end
        end else if (ph_r == PH_BIT_SPACE) begin
          if (mk || (!hit_one && !hit_short)) begin
            vd_nxt = V_REJECT;
            ph_nxt = PH_TAIL;
          end else begin
            if (hit_one) begin
              sh_nxt[idx_r[4:0]] = 1'b1;
            end
            idx_nxt = idx_r + 6'd1;
            if (idx_r == IDX_LAST) begin
              vd_nxt = V_DATA;
              ph_nxt = PH_TAIL;
            end else begin
              ph_nxt = PH_BIT_MARK;
            end
          end
        end
      end
      default: ;
    endcase
  end

  // result as seen after this pulse
  always_comb begin
    lo  = sh_nxt[7:0];
    hi  = sh_nxt[15:8];
    cmd = sh_nxt[23:16];
    inv = sh_nxt[31:24];
    in_bits = (ph_nxt == PH_BIT_MARK) || (ph_nxt == PH_BIT_SPACE) || (ph_nxt == PH_TAIL);
    result = '{status: ST_REJECT, address: 16'd0, command: 8'd0, short_address: 1'b0};
    if (in_bits) begin
      if (ahc_nxt <= AHC_SHORT_MAX) begin
        result.status = fao_nxt ? ST_REPEAT : ST_REJECT;
      end else if (vd_nxt == V_DATA && inv == (cmd ^ BYTE_ONES)) begin
        result.status  = ST_FRAME;
        result.command = cmd;
        if (hi == (lo ^ BYTE_ONES)) begin
          result.short_address = 1'b1;
          result.address       = {8'd0, lo};
        end else begin
          result.address = {hi, lo};
        end
      end
    end else if (vd_nxt == V_REPEAT) begin
      result.status = ST_REPEAT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && pulse.last)) begin
      ph_r  <= PH_HDR_MARK;
      idx_r <= '0;
      sh_r  <= '0;
      ahc_r <= '0;
      fao_r <= 1'b0;
      vd_r  <= V_UNDECIDED;
    end else if (step) begin
      ph_r  <= ph_nxt;
      idx_r <= idx_nxt;
      sh_r  <= sh_nxt;
      ahc_r <= ahc_nxt;
      fao_r <= fao_nxt;
      vd_r  <= vd_nxt;
    end
  end

  a_clear_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    step && pulse.last |=> ph_r == PH_HDR_MARK && vd_r == V_UNDECIDED && ahc_r == '0)
    else $error("frame state not cleared after last pulse");

  a_data_full: assert property (@(posedge clk) disable iff (!rst_n)
    vd_r == V_DATA |-> idx_r == IDX_W'(DATA_W) && ph_r == PH_TAIL)
    else $error("data verdict without all bits");

  a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (ph_r == PH_BIT_MARK || ph_r == PH_BIT_SPACE) |-> idx_r < IDX_W'(DATA_W))
    else $error("bit index out of range while collecting");

endmodule
`default_nettype wire

// ----- hw/rtl/nec_ir_frame_decoder_core.sv -----
`default_nettype none
// A frame's result is registered when its last pulse advances. Throughput: one pulse
//   per cycle, a last pulse stalling while a result is pending; the window compares and
//   frame state update sit in a single stage between the input and result registers.
// Reset (rst_n low, synchronous): frame state returns to expecting a header mark,
//   both item valids clear, tolerances return to 25 and 30 percent.
module nec_ir_frame_decoder_core
  import nec_ir_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire in_item_t             in_item,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output out_item_t                 out_item,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [TOL_W-1:0]     cfg_data
);

  logic      in_valid_r;
  in_item_t  in_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  tol_cfg_t  tol_r;
  out_item_t result;
  logic      adv;

  assign adv       = in_valid_r && (!in_item_r.last || !out_valid_r || out_ready);
  assign in_ready  = !in_valid_r || adv;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  nec_ir_fsm u_fsm (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (adv),
    .pulse  (in_item_r),
    .tol    (tol_r),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      tol_r       <= '{hdr_tol: HDR_TOL_RST, bit_tol: BIT_TOL_RST};
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv && in_item_r.last) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid) begin
        if (cfg_index == CFG_HDR_TOL) begin
          tol_r.hdr_tol <= cfg_data;
        end else if (cfg_index == CFG_BIT_TOL) begin
          tol_r.bit_tol <= cfg_data;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_item_r <= in_item;
    end
    if (adv && in_item_r.last) begin
      out_item_r <= result;
    end
  end

  a_result_from_last: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(adv && in_item_r.last))
    else $error("result raised without a last pulse");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_valid_r |-> in_ready)
    else $error("input stage empty but not ready");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !(adv && in_item_r.last))
    else $error("pending result overwritten");

endmodule
`default_nettype wire
